/* hw/rtl/ukvt_pkg.sv */
// Shared types and constants for the unsorted key and data table unit.
// Used by the table unit, its port checker, the reply checker and the testbench; no dependencies.
`default_nettype none

package ukvt_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ENT_W  = KEY_W + DATA_W;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;

  localparam int IN_TDATA_W  = ((KEY_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_PRESENT   = 3'd4
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/ukvt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the table entries; no package dependencies.
`default_nettype none

module ukvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/unsorted_key_value_table_unit.sv */
// Unsorted key and data table: a packed list of pairs searched one entry per cycle.
// Depends on ukvt_pkg and the ukvt_ram entry store.
//
// Usage. Each input transaction carries one request: the request kind in
// in_tuser and the key and data in in_tdata. Each request produces exactly one
// output transaction with the data found, the entry count in out_tdata and the
// status in out_tuser.
// Timing. The block works on one request at a time and deasserts in_tready
// from acceptance until its result is loaded into the output register; out_tvalid
// and in_tready rise at the same edge. Clear, insert into a full table, and take
// or read on an empty table skip the search and go straight to the output state.
// A search reads one entry per cycle from the entry RAM, and a take that hits
// then moves every later entry down one place through the same RAM port.
// Reset empties the table at once; there is no clearing pass. A stalled output
// holds its result, and a finished request waits for the output register to
// free up; in_tready stays low until then.
`default_nettype none

module unsorted_key_value_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ukvt_pkg::IN_TDATA_W-1:0]   in_tdata,   // key, data_in
  input  logic [ukvt_pkg::REQ_W-1:0]        in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ukvt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // data_out, count, zero fill
  output logic [ukvt_pkg::STAT_W-1:0]       out_tuser   // status
);

  import ukvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic                in_tready_r, in_tready_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  req_t                req_r, req_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [DATA_W-1:0]   din_r, din_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  status_t             res_st_r, res_st_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [DATA_W-1:0]   rd_data;

  assign rd_key  = ram_rdata[ENT_W-1:DATA_W];
  assign rd_data = ram_rdata[DATA_W-1:0];

  ukvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    in_tready_nxt  = in_tready_r;
    out_tvalid_nxt = out_tvalid_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    din_nxt        = din_r;
    res_data_nxt   = res_data_r;
    res_st_nxt     = res_st_r;
    out_data_nxt   = out_data_r;
    out_st_nxt     = out_st_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[IDX_W-1:0];
    ram_wdata      = {key_r, din_r};
    ram_raddr      = scan_r[IDX_W-1:0];

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready_nxt = 1'b1;
        if (in_tvalid && in_tready_r) begin
          in_tready_nxt = 1'b0;
          req_nxt       = req_t'(in_tuser);
          key_nxt       = in_tdata[KEY_W-1:0];
          din_nxt       = in_tdata[KEY_W+DATA_W-1:KEY_W];
          res_data_nxt  = '0;
          res_st_nxt    = ST_OK;
          scan_nxt      = '0;
          pend_nxt      = 1'b0;
          case (req_t'(in_tuser))
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_OUT;
            end
            REQ_INSERT: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else begin
                state_nxt  = S_SEARCH;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                state_nxt  = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (pend_r && (rd_key == key_r)) begin
          pend_nxt = 1'b0;
          if (req_r == REQ_INSERT) begin
            res_st_nxt = ST_PRESENT;
            state_nxt  = S_OUT;
          end else begin
            res_data_nxt = rd_data;
            res_st_nxt   = ST_OK;
            if (req_r == REQ_TAKE) begin
              scan_nxt  = CNT_W'(idx_r) + CNT_W'(1);
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end else if (scan_r < cnt_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_OUT;
          if (req_r == REQ_INSERT) begin
            ram_we     = 1'b1;
            cnt_nxt    = cnt_r + CNT_W'(1);
            res_st_nxt = ST_OK;
          end else begin
            res_st_nxt = ST_NOT_FOUND;
          end
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = ram_rdata;
        end
        if (scan_r < cnt_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = IDX_W'(scan_r - CNT_W'(1));
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_data_r;
          out_st_nxt     = res_st_r;
          out_cnt_nxt    = cnt_r;
          in_tready_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      scan_r       <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cnt_r        <= cnt_nxt;
      scan_r       <= scan_nxt;
      pend_r       <= pend_nxt;
    end
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    din_r      <= din_nxt;
    res_data_r <= res_data_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_cnt_r, out_data_r});
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire

/* hw/rtl/ukvt_chk.sv */
// Port checker for the unsorted key and data table unit, bound to the top level.
// Depends on ukvt_pkg and unsorted_key_value_table_unit.
`default_nettype none

module ukvt_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ukvt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic [ukvt_pkg::STAT_W-1:0]       out_tuser
);

  import ukvt_pkg::*;

  logic [DATA_W-1:0] chk_data;
  logic [CNT_W-1:0]  chk_cnt;

  assign chk_data = out_tdata[DATA_W-1:0];
  assign chk_cnt  = out_tdata[DATA_W+CNT_W-1:DATA_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted again before the request finished.");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> chk_data == '0)
    else $error("Failed request returned nonzero data.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> chk_cnt == CNT_W'(DEPTH))
    else $error("Full status with a table that is not full.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> chk_cnt == '0)
    else $error("Empty status with entries in the table.");

endmodule

bind unsorted_key_value_table_unit ukvt_chk u_ukvt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* sim/ukvt_reply_checker.sv */
// Checker for the unsorted key and data table unit: watches both stream ports, predicts each
// reply from the accepted requests and compares it field by field with what comes out.
// Depends on ukvt_pkg.
module ukvt_reply_checker
  import ukvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [REQ_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STAT_W-1:0]      out_tuser,
  output int                     fail_count,
  output int                     pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic [KEY_W-1:0]  keys_held [DEPTH];
  logic [DATA_W-1:0] data_held [DEPTH];
  int                held;
  reply_t            replies [$];

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < held; i++) begin
      if (keys_held[i] == k) return i;
    end
    return -1;
  endfunction

  task automatic serve_request(input req_t r, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] d, output reply_t rep);
    int slot;
    rep.data   = '0;
    rep.status = ST_OK;
    case (r)
      REQ_CLEAR: begin
        held = 0;
      end
      REQ_INSERT: begin
        if (held >= DEPTH) begin
          rep.status = ST_FULL;
        end else if (find_slot(k) >= 0) begin
          rep.status = ST_PRESENT;
        end else begin
          keys_held[held] = k;
          data_held[held] = d;
          held++;
        end
      end
      default: begin
        slot = find_slot(k);
        if (held == 0) begin
          rep.status = ST_EMPTY;
        end else if (slot < 0) begin
          rep.status = ST_NOT_FOUND;
        end else begin
          rep.data = data_held[slot];
          if (r == REQ_TAKE) begin
            for (int j = slot + 1; j < held; j++) begin
              keys_held[j-1] = keys_held[j];
              data_held[j-1] = data_held[j];
            end
            held--;
          end
        end
      end
    endcase
    rep.count = CNT_W'(held);
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    logic   bad;
    bad = 1'b0;
    if (!rst_n) begin
      held = 0;
      replies.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        serve_request(req_t'(in_tuser), in_tdata[KEY_W-1:0], in_tdata[KEY_W +: DATA_W], want);
        replies.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.data   = out_tdata[DATA_W-1:0];
        got.count  = out_tdata[DATA_W +: CNT_W];
        got.status = status_t'(out_tuser);
        if (replies.size() == 0) begin
          $display("%0t: unexpected transaction, data_out %h status %0d count %0d",
                   $time, got.data, got.status, got.count);
          bad = 1'b1;
        end else begin
          want = replies.pop_front();
          if (got.data !== want.data) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data, got.data);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            bad = 1'b1;
          end
        end
      end
      if (bad) fail_count <= fail_count + 1;
      pending_results <= replies.size();
    end
  end

endmodule

/* sim/tb.sv */
// Top of the table unit testbench: clock, reset, request stimulus and the final verdict.
// Depends on ukvt_pkg, unsorted_key_value_table_unit and ukvt_reply_checker.
module tb;
  import ukvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 50;
  localparam int POOL_SIZE = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  int fail_count;
  int pending_results;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  unsorted_key_value_table_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ukvt_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic issue(input req_t r, input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[KEY_W-1:0] = k;
    word[KEY_W +: DATA_W] = d;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Keys mostly come from a small pool so that lookups hit and the table fills up;
  // the insert share swings so that runs of full and of empty tables both occur.
  task automatic issue_random(input int n);
    int roll;
    int ins_pct;
    logic [KEY_W-1:0] k;
    ins_pct = 50;
    for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = KEY_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 75;
          1: ins_pct = 45;
          default: ins_pct = 20;
        endcase
      end
      if ($urandom_range(0, 99) < 80) begin
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        k = KEY_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        issue(REQ_CLEAR, k, DATA_W'($urandom));
      end else if (roll < 2 + ins_pct) begin
        issue(REQ_INSERT, k, DATA_W'($urandom));
      end else if (roll % 2 == 0) begin
        issue(REQ_TAKE, k, DATA_W'($urandom));
      end else begin
        issue(REQ_READ, k, DATA_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(REQ_CLEAR, '0, '0);
    issue(REQ_TAKE, 16'h1234, '0);
    issue(REQ_READ, 16'h1234, '0);
    issue(REQ_INSERT, '0, '0);
    issue(REQ_INSERT, '1, '1);
    issue(REQ_INSERT, '0, 32'h5a5a_a5a5);
    issue(REQ_READ, 16'h1234, '1);
    issue(REQ_TAKE, '0, '1);
    for (int i = 0; i < DEPTH - 1; i++) begin
      issue(REQ_INSERT, KEY_W'(16'h0100 + i), DATA_W'($urandom));
    end
    issue(REQ_INSERT, 16'h7777, '1);
    issue(REQ_TAKE, '1, '0);
    issue(REQ_READ, KEY_W'(16'h0100 + DEPTH - 2), '0);
    issue(REQ_CLEAR, '1, '1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      issue_random(300);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
